/* sv/assert_macros.svh */
// Assertion macros shared by the climate hysteresis controller RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property every clock, masked while reset is high.
`define CHC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property every clock, reset cycles included.
`define CHC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CHC_ASSERT(label, clk, rst, prop, msg)
`define CHC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* sv/chc_pkg.sv */
// Shared types and constants of the climate hysteresis controller.
// No dependencies; every module file refers to it by scoped names.
package chc_pkg;

  localparam int TEMP_W    = 11;
  localparam int HUM_W     = 10;
  localparam int COUNT_W   = 8;
  localparam int PHASE_W   = 5;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  // Default timing parameters
  localparam int HEAT_DELAY_DEFAULT   = 5;
  localparam int VENT_DELAY_DEFAULT   = 10;
  localparam int MANUAL_TICKS_DEFAULT = 100;
  localparam int SLOW_BLINK_DEFAULT   = 5;
  localparam int IDLE_FLASH_DEFAULT   = 20;

  // Divide by three: floor(x / 3) == (x * 2731) >> 13 for 0 <= x <= 3072
  localparam int          RECIP3_W     = 12;
  localparam logic [11:0] RECIP3       = 12'd2731;
  localparam int          RECIP3_SHIFT = 13;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_PRESS  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAT_CRIT_FIRST = 3'd0,
    REG_HEAT_CRIT_AVG   = 3'd1,
    REG_HEAT_LOW        = 3'd2,
    REG_HEAT_OFF        = 3'd3,
    REG_VENT_OPEN       = 3'd4,
    REG_VENT_CLOSE      = 3'd5,
    REG_DRY             = 3'd6,
    REG_WET             = 3'd7
  } reg_index_t;

  localparam logic signed [TEMP_W-1:0] HEAT_CRIT_FIRST_RST = 11'sd10;
  localparam logic signed [TEMP_W-1:0] HEAT_CRIT_AVG_RST   = 11'sd50;
  localparam logic signed [TEMP_W-1:0] HEAT_LOW_RST        = 11'sd40;
  localparam logic signed [TEMP_W-1:0] HEAT_OFF_RST        = 11'sd60;
  localparam logic signed [TEMP_W-1:0] VENT_OPEN_RST       = 11'sd280;
  localparam logic signed [TEMP_W-1:0] VENT_CLOSE_RST      = 11'sd240;
  localparam logic [HUM_W-1:0]         DRY_RST             = 10'd400;
  localparam logic [HUM_W-1:0]         WET_RST             = 10'd600;

  typedef struct packed {
    logic signed [TEMP_W-1:0] heat_crit_first;
    logic signed [TEMP_W-1:0] heat_crit_avg;
    logic signed [TEMP_W-1:0] heat_low;
    logic signed [TEMP_W-1:0] heat_off;
    logic signed [TEMP_W-1:0] vent_open;
    logic signed [TEMP_W-1:0] vent_close;
    logic [HUM_W-1:0]         dry;
    logic [HUM_W-1:0]         wet;
  } cfg_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [TEMP_W-1:0] temp_first;
    logic signed [TEMP_W-1:0] temp_second;
    logic signed [TEMP_W-1:0] temp_third;
    logic [HUM_W-1:0]         humidity;
  } item_t;

  // Climate status handed from the climate unit to the timer unit
  typedef struct packed {
    logic heater;
    logic vents;
    logic auto_water;
  } climate_t;

endpackage

/* sv/chc_climate.sv */
// Sample-driven heater, vent and automatic watering hysteresis for the controller.
// Depends on chc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chc_climate #(
  parameter int HEAT_DELAY_SAMPLES = chc_pkg::HEAT_DELAY_DEFAULT,
  parameter int VENT_DELAY_SAMPLES = chc_pkg::VENT_DELAY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_en,
  input  chc_pkg::item_t   item,
  input  chc_pkg::cfg_t    cfg,
  output chc_pkg::climate_t status,
  output chc_pkg::climate_t status_next
);

  localparam int SUM_W = chc_pkg::TEMP_W + 2;
  localparam int MAG_W = chc_pkg::RECIP3_W;
  localparam int PRD_W = MAG_W + chc_pkg::RECIP3_W;
  localparam int QUO_W = PRD_W - chc_pkg::RECIP3_SHIFT;
  localparam logic [chc_pkg::COUNT_W-1:0] HEAT_DELAY = chc_pkg::COUNT_W'(HEAT_DELAY_SAMPLES);
  localparam logic [chc_pkg::COUNT_W-1:0] VENT_DELAY = chc_pkg::COUNT_W'(VENT_DELAY_SAMPLES);
  localparam logic [chc_pkg::COUNT_W-1:0] COUNT_MAX  = '1;

  logic                          heater, heater_next;
  logic                          vents, vents_next;
  logic                          auto_water, auto_water_next;
  logic [chc_pkg::COUNT_W-1:0]   low_cnt, low_cnt_next, low_cnt_inc;
  logic [chc_pkg::COUNT_W-1:0]   high_cnt, high_cnt_next, high_cnt_inc;

  logic signed [SUM_W-1:0]       sum;
  logic [MAG_W-1:0]              mag;
  logic [PRD_W-1:0]              prod;
  logic [QUO_W-1:0]              quo;
  logic signed [SUM_W-1:0]       avg;

  // Average truncated toward zero: divide the magnitude, restore the sign
  always_comb begin
    sum  = SUM_W'(item.temp_first) + SUM_W'(item.temp_second) + SUM_W'(item.temp_third);
    mag  = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    prod = PRD_W'(mag) * PRD_W'(chc_pkg::RECIP3);
    quo  = prod[PRD_W-1:chc_pkg::RECIP3_SHIFT];
    avg  = sum[SUM_W-1] ? -SUM_W'(signed'({1'b0, quo})) : SUM_W'(signed'({1'b0, quo}));
  end

  always_comb begin
    low_cnt_inc  = (low_cnt == COUNT_MAX) ? low_cnt : low_cnt + 1'b1;
    high_cnt_inc = (high_cnt == COUNT_MAX) ? high_cnt : high_cnt + 1'b1;

    heater_next     = heater;
    low_cnt_next    = low_cnt;
    vents_next      = vents;
    high_cnt_next   = high_cnt;
    auto_water_next = auto_water;

    if (!heater) begin
      if (item.temp_first <= cfg.heat_crit_first ||
          avg <= SUM_W'(cfg.heat_crit_avg)) begin
        heater_next = 1'b1;
      end else if (item.temp_first < cfg.heat_low) begin
        low_cnt_next = low_cnt_inc;
        heater_next  = (low_cnt_inc >= HEAT_DELAY);
      end else begin
        low_cnt_next = '0;
      end
    end else if (item.temp_first >= cfg.heat_off) begin
      heater_next  = 1'b0;
      low_cnt_next = '0;
    end

    if (!vents) begin
      if (item.temp_third > cfg.vent_open) begin
        high_cnt_next = high_cnt_inc;
        vents_next    = (high_cnt_inc >= VENT_DELAY);
      end else begin
        high_cnt_next = '0;
      end
    end else if (item.temp_third <= cfg.vent_close) begin
      vents_next    = 1'b0;
      high_cnt_next = '0;
    end

    if (!auto_water) begin
      auto_water_next = (item.humidity < cfg.dry);
    end else if (item.humidity >= cfg.wet) begin
      auto_water_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heater     <= 1'b0;
      vents      <= 1'b0;
      auto_water <= 1'b0;
      low_cnt    <= '0;
      high_cnt   <= '0;
    end else if (sample_en) begin
      heater     <= heater_next;
      vents      <= vents_next;
      auto_water <= auto_water_next;
      low_cnt    <= low_cnt_next;
      high_cnt   <= high_cnt_next;
    end
  end

  assign status      = '{heater: heater, vents: vents, auto_water: auto_water};
  assign status_next = sample_en
                       ? '{heater: heater_next, vents: vents_next, auto_water: auto_water_next}
                       : status;

  `CHC_ASSERT(a_heat_run_below_delay, clk, rst, !heater |-> low_cnt < HEAT_DELAY, "low run reached delay with heater off")
  `CHC_ASSERT(a_vent_run_below_delay, clk, rst, !vents |-> high_cnt < VENT_DELAY, "high run reached delay with vents closed")

endmodule

/* sv/chc_timer.sv */
// Manual watering countdown and status LED pattern of the controller.
// Depends on chc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chc_timer #(
  parameter int MANUAL_WATER_TICKS = chc_pkg::MANUAL_TICKS_DEFAULT,
  parameter int SLOW_BLINK_TICKS   = chc_pkg::SLOW_BLINK_DEFAULT,
  parameter int IDLE_FLASH_TICKS   = chc_pkg::IDLE_FLASH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              press_en,
  input  logic              tick_en,
  input  chc_pkg::climate_t climate,
  output logic              manual_next,
  output logic              led_next
);

  localparam int PW = chc_pkg::PHASE_W;
  localparam int PHASES = 2 ** PW;
  localparam logic [chc_pkg::COUNT_W-1:0] MANUAL_LOAD = chc_pkg::COUNT_W'(MANUAL_WATER_TICKS);
  localparam logic [PW-1:0] PHASE_LAST = PW'(IDLE_FLASH_TICKS - 1);

  // Bit i set when phase i is a multiple of the slow blink period
  function automatic logic [PHASES-1:0] slow_mask(input int period);
    logic [PHASES-1:0] mask;
    int                j;
    mask = '0;
    j    = 0;
    for (int i = 0; i < PHASES; i++) begin
      mask[i] = (j == 0);
      j = (j == period - 1) ? 0 : j + 1;
    end
    return mask;
  endfunction

  localparam logic [PHASES-1:0] SLOW_HIT = slow_mask(SLOW_BLINK_TICKS);

  logic                        manual;
  logic [chc_pkg::COUNT_W-1:0] countdown, countdown_next, countdown_dec;
  logic [PW-1:0]               phase, phase_next;
  logic                        led;

  always_comb begin
    manual_next    = manual;
    countdown_next = countdown;
    phase_next     = phase;
    led_next       = led;
    countdown_dec  = (countdown != '0) ? countdown - 1'b1 : countdown;

    if (press_en) begin
      manual_next    = 1'b1;
      countdown_next = MANUAL_LOAD;
    end else if (tick_en) begin
      if (manual) begin
        countdown_next = countdown_dec;
        manual_next    = (countdown_dec != '0);
      end
      phase_next = (phase == PHASE_LAST) ? '0 : phase + 1'b1;

      if (climate.auto_water || manual_next) begin
        led_next = 1'b1;
      end else if (climate.heater) begin
        led_next = !led;
      end else if (climate.vents) begin
        if (SLOW_HIT[phase_next]) begin
          led_next = !led;
        end
      end else if (phase_next == PW'(0)) begin
        led_next = 1'b1;
      end else if (phase_next == PW'(1)) begin
        led_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual    <= 1'b0;
      countdown <= '0;
      phase     <= '0;
      led       <= 1'b0;
    end else begin
      manual    <= manual_next;
      countdown <= countdown_next;
      phase     <= phase_next;
      led       <= led_next;
    end
  end

  `CHC_ASSERT(a_manual_has_count, clk, rst, manual |-> countdown != '0, "manual watering with empty countdown")
  `CHC_ASSERT(a_phase_in_range, clk, rst, phase <= PHASE_LAST, "blink phase past its period")

endmodule

/* sv/climate_hysteresis_controller.sv */
// Top level of the greenhouse climate hysteresis controller.
// Depends on chc_pkg, chc_climate and chc_timer.

// Greenhouse on/off controller. Each input transaction is a sensor sample, a
// manual button press or a 100 ms tick (tuser selects the kind; kind 3 only
// reports the current state), and each one yields exactly one output
// transaction with the heater, vent, sprinkler, manual watering and LED
// drive levels after that item. The block takes one transaction per clock
// while the output is not stalled: an input register holds the item, one pass
// of compare logic (plus a single 12x12 multiply for the divide-by-three
// average) updates the state, and the new drive levels go to an output
// register. An output held by a stalled consumer keeps the input register
// full; once the output is taken the pipe moves on at full rate. Thresholds
// are written through the cfg port and take effect on the next item; write
// them only while no transaction is in flight.
module climate_hysteresis_controller #(
  parameter int HEAT_DELAY_SAMPLES = chc_pkg::HEAT_DELAY_DEFAULT,
  parameter int VENT_DELAY_SAMPLES = chc_pkg::VENT_DELAY_DEFAULT,
  parameter int MANUAL_WATER_TICKS = chc_pkg::MANUAL_TICKS_DEFAULT,
  parameter int SLOW_BLINK_TICKS   = chc_pkg::SLOW_BLINK_DEFAULT,
  parameter int IDLE_FLASH_TICKS   = chc_pkg::IDLE_FLASH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,  // temp_first, temp_second, temp_third, humidity
  input  logic [1:0]                    s_tuser,  // kind
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // heater_on, vents_open, sprinkler_on,
                                                  // manual_active, led_on
  // Threshold register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [chc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int T = chc_pkg::TEMP_W;
  localparam int H = chc_pkg::HUM_W;

  typedef struct packed {
    logic heater_on;
    logic vents_open;
    logic sprinkler_on;
    logic manual_active;
    logic led_on;
  } result_t;

  chc_pkg::cfg_t     cfg;
  chc_pkg::item_t    s1_item;
  logic              s1_valid;
  logic              out_free;
  logic              s1_adv;
  result_t           result, result_next;
  chc_pkg::climate_t climate, climate_next;
  logic              manual_next, led_next;
  logic              sample_en, press_en, tick_en;

  // Configuration: always ready, write the indexed threshold
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_crit_first <= chc_pkg::HEAT_CRIT_FIRST_RST;
      cfg.heat_crit_avg   <= chc_pkg::HEAT_CRIT_AVG_RST;
      cfg.heat_low        <= chc_pkg::HEAT_LOW_RST;
      cfg.heat_off        <= chc_pkg::HEAT_OFF_RST;
      cfg.vent_open       <= chc_pkg::VENT_OPEN_RST;
      cfg.vent_close      <= chc_pkg::VENT_CLOSE_RST;
      cfg.dry             <= chc_pkg::DRY_RST;
      cfg.wet             <= chc_pkg::WET_RST;
    end else if (cfg_valid) begin
      unique case (chc_pkg::reg_index_t'(cfg_index))
        chc_pkg::REG_HEAT_CRIT_FIRST: cfg.heat_crit_first <= signed'(cfg_data);
        chc_pkg::REG_HEAT_CRIT_AVG:   cfg.heat_crit_avg   <= signed'(cfg_data);
        chc_pkg::REG_HEAT_LOW:        cfg.heat_low        <= signed'(cfg_data);
        chc_pkg::REG_HEAT_OFF:        cfg.heat_off        <= signed'(cfg_data);
        chc_pkg::REG_VENT_OPEN:       cfg.vent_open       <= signed'(cfg_data);
        chc_pkg::REG_VENT_CLOSE:      cfg.vent_close      <= signed'(cfg_data);
        chc_pkg::REG_DRY:             cfg.dry             <= cfg_data[H-1:0];
        chc_pkg::REG_WET:             cfg.wet             <= cfg_data[H-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register frees when empty or taken; the input
  // register advances into it and refills in the same cycle
  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (out_free) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.kind        <= chc_pkg::kind_t'(s_tuser);
      s1_item.temp_first  <= signed'(s_tdata[T-1:0]);
      s1_item.temp_second <= signed'(s_tdata[2*T-1:T]);
      s1_item.temp_third  <= signed'(s_tdata[3*T-1:2*T]);
      s1_item.humidity    <= s_tdata[3*T+H-1:3*T];
    end
  end

  // Decode the kind; state moves only when the item leaves the input register
  always_comb begin
    sample_en = 1'b0;
    press_en  = 1'b0;
    tick_en   = 1'b0;
    unique case (s1_item.kind)
      chc_pkg::KIND_SAMPLE: sample_en = s1_adv;
      chc_pkg::KIND_PRESS:  press_en  = s1_adv;
      chc_pkg::KIND_TICK:   tick_en   = s1_adv;
      chc_pkg::KIND_NONE:   ;
      default:              ;
    endcase
  end

  chc_climate #(
    .HEAT_DELAY_SAMPLES (HEAT_DELAY_SAMPLES),
    .VENT_DELAY_SAMPLES (VENT_DELAY_SAMPLES)
  ) u_climate (
    .clk         (clk),
    .rst         (rst),
    .sample_en   (sample_en),
    .item        (s1_item),
    .cfg         (cfg),
    .status      (climate),
    .status_next (climate_next)
  );

  // Ticks never change the climate state, so the timer sees its current value
  chc_timer #(
    .MANUAL_WATER_TICKS (MANUAL_WATER_TICKS),
    .SLOW_BLINK_TICKS   (SLOW_BLINK_TICKS),
    .IDLE_FLASH_TICKS   (IDLE_FLASH_TICKS)
  ) u_timer (
    .clk         (clk),
    .rst         (rst),
    .press_en    (press_en),
    .tick_en     (tick_en),
    .climate     (climate),
    .manual_next (manual_next),
    .led_next    (led_next)
  );

  // Drive levels after this item
  always_comb begin
    result_next.heater_on     = climate_next.heater;
    result_next.vents_open    = climate_next.vents;
    result_next.sprinkler_on  = climate_next.auto_water || manual_next;
    result_next.manual_active = manual_next;
    result_next.led_on        = led_next;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= result_next;
    end
  end

  assign m_tdata = {3'b000, result.led_on, result.manual_active, result.sprinkler_on,
                    result.vents_open, result.heater_on};

endmodule
